// ===== rtl/core/lirr_pkg.sv =====
// Shared types and constants of the linear-interpolation resampler.
package lirr_pkg;

  // Width of the step register as seen on the configuration channel.
  localparam int STEP_W = 20;

  // Most results one source frame may cause, and the counter that tracks them.
  localparam int MAX_OUT = 64;
  localparam int CNT_W   = 6;

  // Smallest step is 1.0 >> MIN_STEP_SHIFT, which caps results per frame at MAX_OUT.
  localparam int MIN_STEP_SHIFT = 6;

  // Control from the sequencer to each channel lane.
  typedef struct packed {
    logic load;   // capture a new segment (start sample and slope)
    logic issue;  // start one interpolation at the current position
  } lirr_lane_ctl_t;

  // Product stage status handed to the merge stage.
  typedef struct packed {
    logic vld;
    logic last;
  } lirr_pipe_t;

endpackage

// ===== rtl/core/lirr_ifs.sv =====
// Handshake channel interfaces of the resampler: source frames, results, step writes.
interface lirr_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;
  logic                           restart;

  modport source (output valid, output left_in, output right_in, output restart, input ready);
  modport sink (input valid, input left_in, input right_in, input restart, output ready);
endinterface

interface lirr_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic                           last;

  modport source (output valid, output left_out, output right_out, output last, input ready);
  modport sink (input valid, input left_out, input right_out, input last, output ready);
endinterface

interface lirr_cfg_if import lirr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step;

  modport source (output valid, output step, input ready);
  modport sink (input valid, input step, output ready);
endinterface

// ===== rtl/core/lirr_lane.sv =====
// One channel lane: holds the segment and forms the rounded position-times-slope product.
module lirr_lane import lirr_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                 clk,
  input  lirr_lane_ctl_t                       ctl,
  input  logic [SAMPLE_WIDTH-1:0]              seg_start,
  input  logic [SAMPLE_WIDTH-1:0]              seg_end,
  input  logic [FRAC_BITS:0]                   pos_t,
  output logic [SAMPLE_WIDTH-1:0]              p_base,
  output logic [SAMPLE_WIDTH+FRAC_BITS+1:0]    p_prod
);

  localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic        [SAMPLE_WIDTH-1:0] base_r;
  logic signed [SAMPLE_WIDTH:0]   slope_r;
  logic signed [SAMPLE_WIDTH:0]   slope_nxt;
  logic        [SAMPLE_WIDTH-1:0] p_base_r;
  logic signed [PW-1:0]           p_prod_r;
  logic signed [PW-1:0]           t_ext;
  logic signed [PW-1:0]           slope_ext;
  logic signed [PW-1:0]           prod_nxt;

  assign slope_nxt = $signed({seg_end[SAMPLE_WIDTH-1], seg_end})
                   - $signed({seg_start[SAMPLE_WIDTH-1], seg_start});

  assign t_ext     = $signed({{(PW - FRAC_BITS - 1){1'b0}}, pos_t});
  assign slope_ext = $signed({{(PW - SAMPLE_WIDTH - 1){slope_r[SAMPLE_WIDTH]}}, slope_r});
  assign prod_nxt  = t_ext * slope_ext + HALF;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      base_r  <= seg_start;
      slope_r <= slope_nxt;
    end
    // carry the start sample along so a new segment may load behind this product
    if (ctl.issue) begin
      p_base_r <= base_r;
      p_prod_r <= prod_nxt;
    end
  end

  assign p_base = p_base_r;
  assign p_prod = p_prod_r;

endmodule

// ===== rtl/core/lirr_merge.sv =====
// Merge stage: adds each lane's rounded offset to its start sample into the output register.
module lirr_merge import lirr_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int FRAC_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lirr_pipe_t                        pipe,
  input  logic [SAMPLE_WIDTH-1:0]           base_lt,
  input  logic [SAMPLE_WIDTH+FRAC_BITS+1:0] prod_lt,
  input  logic [SAMPLE_WIDTH-1:0]           base_rt,
  input  logic [SAMPLE_WIDTH+FRAC_BITS+1:0] prod_rt,
  output logic                              take,
  lirr_out_if.source                        out_ch
);

  logic                    o_vld_r;
  logic                    o_last_r;
  logic [SAMPLE_WIDTH-1:0] o_lt_r;
  logic [SAMPLE_WIDTH-1:0] o_rt_r;

  // The arithmetic shift of the rounded product is a plain bit slice, low bits dropped.
  assign take = !o_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (take) begin
      o_vld_r <= pipe.vld;
    end
    if (take && pipe.vld) begin
      o_lt_r   <= base_lt + prod_lt[FRAC_BITS +: SAMPLE_WIDTH];
      o_rt_r   <= base_rt + prod_rt[FRAC_BITS +: SAMPLE_WIDTH];
      o_last_r <= pipe.last;
    end
  end

  assign out_ch.valid     = o_vld_r;
  assign out_ch.left_out  = o_lt_r;
  assign out_ch.right_out = o_rt_r;
  assign out_ch.last      = o_last_r;

endmodule

// ===== rtl/core/linear_interp_rate_resampler_unit.sv =====
// Top level of the stereo linear-interpolation resampler.
//
// Each source frame transfer on in_ch starts a segment from the stored frame to the new one.
// While the Q(FRAC_BITS) position is at or below 1.0, and out_ch does not stall, the block
// emits one interpolated frame per cycle, stepping the position by the step register, then
// drops 1.0 from the position and keeps the new frame. Each item causes 0 to 64 results,
// issued by the position accumulator one interpolation a cycle; the next frame transfers
// the cycle after the final result is issued, while up to two results still drain. A stall
// on out_ch holds the issue loop. Results pass a product register in each lane, then the
// output register of the merge stage. Write step only while idle; a write saturates it at
// 1.0/64 from below and sets the position back to 1.0.
module linear_interp_rate_resampler_unit import lirr_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int FRAC_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lirr_in_if.sink    in_ch,
  lirr_out_if.source out_ch,
  lirr_cfg_if.sink   cfg_ch
);

  // Position holds 1.0 plus the largest step without wrapping.
  localparam int POS_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int PW    = SAMPLE_WIDTH + FRAC_BITS + 2;

  localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] MIN_STEP = ONE_POS >> MIN_STEP_SHIFT;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state_r, state_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        step_r;
  logic signed [POS_W:0]   step_m1_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SAMPLE_WIDTH-1:0] prev_lt_r, prev_rt_r;
  logic                    p_vld_r, p_vld_nxt;
  logic                    p_last_r;

  logic                    in_xfer, cfg_xfer;
  logic                    take, p_free, issue, last_issue;
  logic [POS_W-1:0]        cfg_step, step_sat;
  logic [POS_W-1:0]        t_entry;
  logic [POS_W-1:0]        pos_sum;
  logic signed [POS_W:0]   pos_adj;
  logic [SAMPLE_WIDTH-1:0] seg_lt, seg_rt;

  lirr_lane_ctl_t          lane_ctl;
  lirr_pipe_t              pipe;
  logic [SAMPLE_WIDTH-1:0] base_lt, base_rt;
  logic [PW-1:0]           prod_lt, prod_rt;

  // Step writes go first when both channels offer in the same cycle.
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // Saturate small steps so one frame never yields more than MAX_OUT results.
  assign cfg_step = POS_W'(cfg_ch.step);
  assign step_sat = (cfg_step < MIN_STEP) ? MIN_STEP : cfg_step;

  // Restart takes the stored frame as zero and the position as 1.0 for the segment it starts.
  assign t_entry = in_ch.restart ? ONE_POS : pos_r;
  assign seg_lt  = in_ch.restart ? '0 : prev_lt_r;
  assign seg_rt  = in_ch.restart ? '0 : prev_rt_r;

  // Issue one interpolation in the run state whenever the product stage has room.
  assign p_free     = !p_vld_r || take;
  assign issue      = (state_r == ST_RUN) && p_free;
  assign pos_sum    = pos_r + step_r;
  assign pos_adj    = $signed({1'b0, pos_r}) + step_m1_r;
  assign last_issue = (pos_sum > ONE_POS) || (cnt_r == CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_xfer) begin
          pos_nxt = ONE_POS;
        end else if (in_xfer) begin
          cnt_nxt = '0;
          if (t_entry > ONE_POS) begin
            // no result: skip this frame, drop 1.0 from the position
            pos_nxt = t_entry - ONE_POS;
          end else begin
            pos_nxt   = t_entry;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last_issue) begin
            // leave the segment: position minus 1.0, floored at zero
            pos_nxt   = pos_adj[POS_W] ? '0 : pos_adj[POS_W-1:0];
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_sum;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (issue) begin
      p_vld_nxt = 1'b1;
    end else if (take) begin
      p_vld_nxt = 1'b0;
    end else begin
      p_vld_nxt = p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= ONE_POS;
      step_r    <= ONE_POS;
      step_m1_r <= '0;
      cnt_r     <= '0;
      prev_lt_r <= '0;
      prev_rt_r <= '0;
      p_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      p_vld_r <= p_vld_nxt;
      if (cfg_xfer) begin
        step_r    <= step_sat;
        step_m1_r <= $signed({1'b0, step_sat}) - $signed({1'b0, ONE_POS});
      end
      // the new frame becomes the stored frame once it has transferred
      if (in_xfer) begin
        prev_lt_r <= in_ch.left_in;
        prev_rt_r <= in_ch.right_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_last_r <= last_issue;
    end
  end

  assign lane_ctl.load  = in_xfer;
  assign lane_ctl.issue = issue;
  assign pipe.vld       = p_vld_r;
  assign pipe.last      = p_last_r;

  lirr_lane #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_lane_lt (
    .clk       (clk),
    .ctl       (lane_ctl),
    .seg_start (seg_lt),
    .seg_end   (in_ch.left_in),
    .pos_t     (pos_r[FRAC_BITS:0]),
    .p_base    (base_lt),
    .p_prod    (prod_lt)
  );

  lirr_lane #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_lane_rt (
    .clk       (clk),
    .ctl       (lane_ctl),
    .seg_start (seg_rt),
    .seg_end   (in_ch.right_in),
    .pos_t     (pos_r[FRAC_BITS:0]),
    .p_base    (base_rt),
    .p_prod    (prod_rt)
  );

  lirr_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .pipe    (pipe),
    .base_lt (base_lt),
    .prod_lt (prod_lt),
    .base_rt (base_rt),
    .prod_rt (prod_rt),
    .take    (take),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the stereo linear-interpolation resampler.
module testbench;
  import lirr_pkg::*;

  localparam int SW       = 24;
  localparam int FRAC     = 16;
  localparam int ONE_POS  = 1 << FRAC;
  localparam int MIN_STEP = ONE_POS >> MIN_STEP_SHIFT;
  localparam int HOLD_LEN = 300;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } out_frame_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n;

  lirr_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  lirr_out_if #(.SAMPLE_WIDTH(SW)) out_if ();
  lirr_cfg_if                      cfg_if ();

  linear_interp_rate_resampler_unit #(
    .SAMPLE_WIDTH(SW),
    .FRAC_BITS   (FRAC)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #4 clk = ~clk;

  // Predictor state: step register, stored frame and position.
  int         cur_step;
  int         phase_pos;
  sample_t    held_left;
  sample_t    held_right;
  out_frame_t pending_outputs[$];

  int fail_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  logic hold_req = 1'b0;

  // a + t*(b-a), rounded to nearest with halves going up.
  function automatic sample_t interp(sample_t a, sample_t b, int t);
    longint prod;
    prod = longint'(t) * (longint'(b) - longint'(a)) + longint'(ONE_POS / 2);
    return sample_t'(longint'(a) + (prod >>> FRAC));
  endfunction

  // Work out every output frame that one source frame causes.
  function automatic void resample_frame(sample_t l, sample_t r, logic rs);
    out_frame_t f;
    int n;
    if (rs) begin
      held_left  = '0;
      held_right = '0;
      phase_pos  = ONE_POS;
    end
    n = 0;
    while (phase_pos <= ONE_POS && n < MAX_OUT) begin
      f.left  = interp(held_left, l, phase_pos);
      f.right = interp(held_right, r, phase_pos);
      f.last  = !((phase_pos + cur_step) <= ONE_POS && (n + 1) < MAX_OUT);
      pending_outputs.push_back(f);
      n++;
      phase_pos += cur_step;
    end
    phase_pos  = (phase_pos >= ONE_POS) ? phase_pos - ONE_POS : 0;
    held_left  = l;
    held_right = r;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return STEP_W'($urandom_range(MIN_STEP, 2 * MIN_STEP));
    if (r < 10) return STEP_W'($urandom_range(0, MIN_STEP - 1));
    if (r < 15) return STEP_W'($urandom);
    if (r < 22) return STEP_W'($urandom_range(4 * ONE_POS, (1 << STEP_W) - 1));
    return STEP_W'($urandom_range(ONE_POS / 8, 2 * ONE_POS));
  endfunction

  // Offer one source frame and hold it until the block takes it; valid stays high.
  task automatic send_frame(input sample_t l, input sample_t r, input logic rs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.left_in  <= l;
    in_if.right_in <= r;
    in_if.restart  <= rs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    resample_frame(l, r, rs);
  endtask

  // Drop the source channel, let the block drain, then write step.
  task automatic write_step(input logic [STEP_W-1:0] v);
    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    // frames without results may still be in flight
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.step  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_step  = (v < MIN_STEP) ? MIN_STEP : int'(v);
    phase_pos = ONE_POS;
  endtask

  // Unity step from reset: every output equals the incoming frame.
  task automatic test_unity_extremes();
    send_frame(S_MAX, S_MIN, 1'b1);
    send_frame(S_MIN, S_MAX, 1'b0);
    send_frame('0, -1, 1'b0);
    send_frame(S_MAX, S_MAX, 1'b0);
    send_frame(S_MIN, S_MIN, 1'b1);
  endtask

  // Half step with odd differences lands exactly on halves.
  task automatic test_rounding_ties();
    write_step(STEP_W'(ONE_POS / 2));
    send_frame(1, -1, 1'b1);
    send_frame(2, -2, 1'b0);
    send_frame(S_MAX, S_MIN, 1'b0);
    send_frame(S_MIN, S_MAX, 1'b0);
  endtask

  // Saturation of small steps (most results per frame) and the largest step (skipped frames).
  task automatic test_step_limits();
    write_step('0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    write_step(STEP_W'(MIN_STEP - 1));
    send_frame(S_MIN, S_MAX, 1'b0);
    send_frame(S_MAX, S_MIN, 1'b0);
    write_step('1);
    repeat (4) send_frame(rand_sample(), rand_sample(), 1'b0);
  endtask

  // Hold the result channel off for a long stretch while frames keep coming.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_step(STEP_W'(ONE_POS / 4));
    hold_req <= ~hold_req;
    repeat (12) send_frame(rand_sample(), rand_sample(), 1'b0);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) write_step(pick_step());
      send_frame(rand_sample(), rand_sample(), $urandom_range(19) == 0);
    end
  endtask

  // Result channel ready: long hold on request, else random stalls.
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest predicted frame.
  initial begin
    out_frame_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d last %0b",
                 out_if.left_out, out_if.right_out, out_if.last);
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_if.left_out !== want.left) begin
            $error("left_out mismatch: expected %0d, actual %0d", want.left, out_if.left_out);
            fail_count++;
          end
          if (out_if.right_out !== want.right) begin
            $error("right_out mismatch: expected %0d, actual %0d", want.right, out_if.right_out);
            fail_count++;
          end
          if (out_if.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_if.last);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int leftover;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.left_in  <= '0;
    in_if.right_in <= '0;
    in_if.restart  <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.step    <= '0;
    cur_step   = ONE_POS;
    phase_pos  = ONE_POS;
    held_left  = '0;
    held_right = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unity_extremes();
    test_rounding_ties();
    test_step_limits();
    test_backpressure();
    test_random_traffic(22, 82, 48);
    test_random_traffic(82, 22, 48);
    test_random_traffic(0, 0, 48);

    in_if.valid <= 1'b0;
    for (int k = 0; k < 50000 && pending_outputs.size() != 0; k++) @(posedge clk);
    leftover = pending_outputs.size();
    if (leftover != 0) $error("%0d predicted results never arrived", leftover);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lirr_pkg.sv
rtl/core/lirr_ifs.sv
rtl/core/lirr_lane.sv
rtl/core/lirr_merge.sv
rtl/core/linear_interp_rate_resampler_unit.sv
tb/testbench.sv
